// File: rtl/cyrillic_codepage_to_utf8_transcoder_defines.svh
// Assertion macros used by the transcoder checker.
`ifndef CYRILLIC_CODEPAGE_TO_UTF8_TRANSCODER_DEFINES_SVH
`define CYRILLIC_CODEPAGE_TO_UTF8_TRANSCODER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define CC2U_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define CC2U_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/cc2u_pkg.sv
// Shared types, constants and code point ROMs of the Cyrillic to UTF-8 transcoder.
`timescale 1ns / 1ps

package cc2u_pkg;

	typedef logic [13:0] code_point_t;

	typedef enum logic [1:0] {
		CP_WIN1251 = 2'd0,
		CP_KOI8R   = 2'd1,
		CP_ISO8859 = 2'd2
	} codepage_t;

	// special bytes
	localparam logic [7:0] WIN_UNMAPPED = 8'h98;
	localparam logic [7:0] ISO_NBSP     = 8'hA0;
	localparam logic [7:0] ISO_SHY      = 8'hAD;
	localparam logic [7:0] ISO_NUMERO   = 8'hF0;
	localparam logic [7:0] ISO_SECTION  = 8'hFD;

	localparam code_point_t CP_SPACE   = 14'h0020;
	localparam code_point_t CP_SHY     = 14'h00AD;
	localparam code_point_t CP_NUMERO  = 14'h2116;
	localparam code_point_t CP_SECTION = 14'h00A7;

	// offsets of the linear Cyrillic ranges
	localparam code_point_t WIN_OFFSET = 14'h0350;
	localparam code_point_t ISO_OFFSET = 14'h0360;

	// UTF-8 length thresholds
	localparam code_point_t ONE_BYTE_LIMIT = 14'h0080;
	localparam code_point_t TWO_BYTE_LIMIT = 14'h0800;

	typedef struct packed {
		logic        bad;
		code_point_t cp;
	} map_res_t;

	typedef struct packed {
		logic [7:0] first;
		logic [7:0] second;
		logic [7:0] third;
		logic [1:0] count;
		logic       bad;
	} utf8_res_t;

	// CP-1251 0x80-0xBF
	function automatic code_point_t win1251_rom(input logic [5:0] idx);
		code_point_t v;
		case (idx)
			6'd0:  v = 14'h0402; 6'd1:  v = 14'h0403; 6'd2:  v = 14'h201A; 6'd3:  v = 14'h0453;
			6'd4:  v = 14'h201E; 6'd5:  v = 14'h2026; 6'd6:  v = 14'h2020; 6'd7:  v = 14'h2021;
			6'd8:  v = 14'h20AC; 6'd9:  v = 14'h2030; 6'd10: v = 14'h0409; 6'd11: v = 14'h2039;
			6'd12: v = 14'h040A; 6'd13: v = 14'h040C; 6'd14: v = 14'h040B; 6'd15: v = 14'h040F;
			6'd16: v = 14'h0452; 6'd17: v = 14'h2018; 6'd18: v = 14'h2019; 6'd19: v = 14'h201C;
			6'd20: v = 14'h201D; 6'd21: v = 14'h2022; 6'd22: v = 14'h2013; 6'd23: v = 14'h2014;
			6'd24: v = 14'h0000; 6'd25: v = 14'h2122; 6'd26: v = 14'h0459; 6'd27: v = 14'h203A;
			6'd28: v = 14'h045A; 6'd29: v = 14'h045C; 6'd30: v = 14'h045B; 6'd31: v = 14'h045F;
			6'd32: v = 14'h0020; 6'd33: v = 14'h040E; 6'd34: v = 14'h045E; 6'd35: v = 14'h0408;
			6'd36: v = 14'h00A4; 6'd37: v = 14'h0490; 6'd38: v = 14'h00A6; 6'd39: v = 14'h00A7;
			6'd40: v = 14'h0401; 6'd41: v = 14'h00A9; 6'd42: v = 14'h0404; 6'd43: v = 14'h00AB;
			6'd44: v = 14'h00AC; 6'd45: v = 14'h00AD; 6'd46: v = 14'h00AE; 6'd47: v = 14'h0407;
			6'd48: v = 14'h00B0; 6'd49: v = 14'h00B1; 6'd50: v = 14'h0406; 6'd51: v = 14'h0456;
			6'd52: v = 14'h0491; 6'd53: v = 14'h00B5; 6'd54: v = 14'h00B6; 6'd55: v = 14'h00B7;
			6'd56: v = 14'h0451; 6'd57: v = 14'h2116; 6'd58: v = 14'h0454; 6'd59: v = 14'h00BB;
			6'd60: v = 14'h0458; 6'd61: v = 14'h0405; 6'd62: v = 14'h0455; 6'd63: v = 14'h0457;
			default: v = '0;
		endcase
		return v;
	endfunction

	// KOI8-R 0x80-0xFF
	function automatic code_point_t koi8r_rom(input logic [6:0] idx);
		code_point_t v;
		case (idx)
			7'd0:   v = 14'h2500; 7'd1:   v = 14'h2502; 7'd2:   v = 14'h250C; 7'd3:   v = 14'h2510;
			7'd4:   v = 14'h2514; 7'd5:   v = 14'h2518; 7'd6:   v = 14'h251C; 7'd7:   v = 14'h2524;
			7'd8:   v = 14'h252C; 7'd9:   v = 14'h2534; 7'd10:  v = 14'h253C; 7'd11:  v = 14'h2580;
			7'd12:  v = 14'h2584; 7'd13:  v = 14'h2588; 7'd14:  v = 14'h258C; 7'd15:  v = 14'h2590;
			7'd16:  v = 14'h2591; 7'd17:  v = 14'h2592; 7'd18:  v = 14'h2593; 7'd19:  v = 14'h2320;
			7'd20:  v = 14'h25A0; 7'd21:  v = 14'h2219; 7'd22:  v = 14'h221A; 7'd23:  v = 14'h2248;
			7'd24:  v = 14'h2264; 7'd25:  v = 14'h2265; 7'd26:  v = 14'h0020; 7'd27:  v = 14'h2321;
			7'd28:  v = 14'h00B0; 7'd29:  v = 14'h00B2; 7'd30:  v = 14'h00B7; 7'd31:  v = 14'h00F7;
			7'd32:  v = 14'h2550; 7'd33:  v = 14'h2551; 7'd34:  v = 14'h2552; 7'd35:  v = 14'h0451;
			7'd36:  v = 14'h2553; 7'd37:  v = 14'h2554; 7'd38:  v = 14'h2555; 7'd39:  v = 14'h2556;
			7'd40:  v = 14'h2557; 7'd41:  v = 14'h2558; 7'd42:  v = 14'h2559; 7'd43:  v = 14'h255A;
			7'd44:  v = 14'h255B; 7'd45:  v = 14'h255C; 7'd46:  v = 14'h255D; 7'd47:  v = 14'h255E;
			7'd48:  v = 14'h255F; 7'd49:  v = 14'h2560; 7'd50:  v = 14'h2561; 7'd51:  v = 14'h0401;
			7'd52:  v = 14'h2562; 7'd53:  v = 14'h2563; 7'd54:  v = 14'h2564; 7'd55:  v = 14'h2565;
			7'd56:  v = 14'h2566; 7'd57:  v = 14'h2567; 7'd58:  v = 14'h2568; 7'd59:  v = 14'h2569;
			7'd60:  v = 14'h256A; 7'd61:  v = 14'h256B; 7'd62:  v = 14'h256C; 7'd63:  v = 14'h00A9;
			7'd64:  v = 14'h044E; 7'd65:  v = 14'h0430; 7'd66:  v = 14'h0431; 7'd67:  v = 14'h0446;
			7'd68:  v = 14'h0434; 7'd69:  v = 14'h0435; 7'd70:  v = 14'h0444; 7'd71:  v = 14'h0433;
			7'd72:  v = 14'h0445; 7'd73:  v = 14'h0438; 7'd74:  v = 14'h0439; 7'd75:  v = 14'h043A;
			7'd76:  v = 14'h043B; 7'd77:  v = 14'h043C; 7'd78:  v = 14'h043D; 7'd79:  v = 14'h043E;
			7'd80:  v = 14'h043F; 7'd81:  v = 14'h044F; 7'd82:  v = 14'h0440; 7'd83:  v = 14'h0441;
			7'd84:  v = 14'h0442; 7'd85:  v = 14'h0443; 7'd86:  v = 14'h0436; 7'd87:  v = 14'h0432;
			7'd88:  v = 14'h044C; 7'd89:  v = 14'h044B; 7'd90:  v = 14'h0437; 7'd91:  v = 14'h0448;
			7'd92:  v = 14'h044D; 7'd93:  v = 14'h0449; 7'd94:  v = 14'h0447; 7'd95:  v = 14'h044A;
			7'd96:  v = 14'h042E; 7'd97:  v = 14'h0410; 7'd98:  v = 14'h0411; 7'd99:  v = 14'h0426;
			7'd100: v = 14'h0414; 7'd101: v = 14'h0415; 7'd102: v = 14'h0424; 7'd103: v = 14'h0413;
			7'd104: v = 14'h0425; 7'd105: v = 14'h0418; 7'd106: v = 14'h0419; 7'd107: v = 14'h041A;
			7'd108: v = 14'h041B; 7'd109: v = 14'h041C; 7'd110: v = 14'h041D; 7'd111: v = 14'h041E;
			7'd112: v = 14'h041F; 7'd113: v = 14'h042F; 7'd114: v = 14'h0420; 7'd115: v = 14'h0421;
			7'd116: v = 14'h0422; 7'd117: v = 14'h0423; 7'd118: v = 14'h0416; 7'd119: v = 14'h0412;
			7'd120: v = 14'h042C; 7'd121: v = 14'h042B; 7'd122: v = 14'h0417; 7'd123: v = 14'h0428;
			7'd124: v = 14'h042D; 7'd125: v = 14'h0429; 7'd126: v = 14'h0427; 7'd127: v = 14'h042A;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/cc2u_in_if.sv
// Valid/ready channel carrying one source byte per beat.
`timescale 1ns / 1ps

interface cc2u_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

// File: rtl/cc2u_out_if.sv
// Valid/ready channel carrying one UTF-8 sequence per beat.
`timescale 1ns / 1ps

interface cc2u_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] utf8_first;
	logic [7:0] utf8_second;
	logic [7:0] utf8_third;
	logic [1:0] byte_count;
	logic       bad_input;

	modport source (output valid, output utf8_first, output utf8_second, output utf8_third,
		output byte_count, output bad_input, input ready);
	modport sink   (input valid, input utf8_first, input utf8_second, input utf8_third,
		input byte_count, input bad_input, output ready);
endinterface

// File: rtl/cc2u_map.sv
// Source byte to Unicode code point per code page: pass-through, ROM, offset or special case.
`timescale 1ns / 1ps

module cc2u_map (
	input  logic [1:0]         codepage,
	input  logic [7:0]         src_byte,
	output cc2u_pkg::map_res_t res
);

	always_comb begin
		res.bad = 1'b0;
		res.cp  = {6'd0, src_byte};
		case (codepage)
			cc2u_pkg::CP_WIN1251: begin
				if (src_byte[7]) begin
					if (src_byte == cc2u_pkg::WIN_UNMAPPED) begin
						res.bad = 1'b1;
						res.cp  = '0;
					end else if (!src_byte[6]) begin
						res.cp = cc2u_pkg::win1251_rom(src_byte[5:0]);
					end else begin
						res.cp = {6'd0, src_byte} + cc2u_pkg::WIN_OFFSET;
					end
				end
			end
			cc2u_pkg::CP_KOI8R: begin
				if (src_byte[7])
					res.cp = cc2u_pkg::koi8r_rom(src_byte[6:0]);
			end
			cc2u_pkg::CP_ISO8859: begin
				if (src_byte[7]) begin
					// control block 0x80-0x9F has no mapping
					if (src_byte < cc2u_pkg::ISO_NBSP) begin
						res.bad = 1'b1;
						res.cp  = '0;
					end else if (src_byte == cc2u_pkg::ISO_NBSP) begin
						res.cp = cc2u_pkg::CP_SPACE;
					end else if (src_byte == cc2u_pkg::ISO_SHY) begin
						res.cp = cc2u_pkg::CP_SHY;
					end else if (src_byte == cc2u_pkg::ISO_NUMERO) begin
						res.cp = cc2u_pkg::CP_NUMERO;
					end else if (src_byte == cc2u_pkg::ISO_SECTION) begin
						res.cp = cc2u_pkg::CP_SECTION;
					end else begin
						res.cp = {6'd0, src_byte} + cc2u_pkg::ISO_OFFSET;
					end
				end
			end
			default: begin
				res.bad = 1'b1;
				res.cp  = '0;
			end
		endcase
	end

endmodule

// File: rtl/cc2u_enc.sv
// Code point to UTF-8 bytes and length; an unmapped byte gives zeros.
`timescale 1ns / 1ps

module cc2u_enc (
	input  cc2u_pkg::map_res_t  map,
	output cc2u_pkg::utf8_res_t res
);

	always_comb begin
		res.first  = '0;
		res.second = '0;
		res.third  = '0;
		res.count  = 2'd0;
		res.bad    = map.bad;
		if (!map.bad) begin
			if (map.cp < cc2u_pkg::ONE_BYTE_LIMIT) begin
				res.first = map.cp[7:0];
				res.count = 2'd1;
			end else if (map.cp < cc2u_pkg::TWO_BYTE_LIMIT) begin
				res.first  = {3'b110, map.cp[10:6]};
				res.second = {2'b10, map.cp[5:0]};
				res.count  = 2'd2;
			end else begin
				res.first  = {4'b1110, 2'b00, map.cp[13:12]};
				res.second = {2'b10, map.cp[11:6]};
				res.third  = {2'b10, map.cp[5:0]};
				res.count  = 2'd3;
			end
		end
	end

endmodule

// File: rtl/cyrillic_codepage_to_utf8_transcoder.sv
// Cyrillic single-byte code page (CP-1251 / KOI8-R / ISO-8859-5) to UTF-8 transcoder.
//
// One byte in, one UTF-8 sequence out per beat, at one byte per clock when not stalled.
// Each byte is captured in an input register; the code point lookup (ROM for CP-1251
// 0x80-0xBF and the KOI8-R upper half, offset arithmetic elsewhere) and the UTF-8 packing
// sit between that register and the result register. A beat passes the input register,
// then the result register; with out_ch.ready held high a new byte is taken every cycle,
// and the result register plus input register give two beats of buffering under back-pressure.
// Output carries up to three UTF-8 bytes (unused ones zero) and byte_count 1..3.
// No-break space in every code page comes out as plain 0x20. CP-1251 0x98,
// ISO-8859-5 0x80-0x9F and any byte under codepage value 3 give bad_input with
// byte_count 0 and zero bytes. codepage resets to CP-1251; write it only while
// the block is idle (no beat in flight).
`timescale 1ns / 1ps

module cyrillic_codepage_to_utf8_transcoder (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_wdata,
	cc2u_in_if.sink         in_ch,
	cc2u_out_if.source      out_ch
);

	logic [1:0]          codepage_q;

	logic                valid_s1;
	logic [7:0]          byte_s1;

	logic                out_valid_q;
	cc2u_pkg::utf8_res_t res_q;

	cc2u_pkg::map_res_t  map_res;
	cc2u_pkg::utf8_res_t enc_res;

	logic                out_adv;
	logic                in_adv;

	// result register frees when empty or being drained this cycle
	assign out_adv     = !out_valid_q || out_ch.ready;
	// input register frees when empty or moving into the result register
	assign in_ch.ready = !valid_s1 || out_adv;
	assign in_adv      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codepage_q <= 2'd0;
		end else if (cfg_we) begin
			codepage_q <= cfg_wdata;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_adv) begin
			byte_s1 <= in_ch.in_byte;
		end
	end

	cc2u_map u_map (
		.codepage (codepage_q),
		.src_byte (byte_s1),
		.res      (map_res)
	);

	cc2u_enc u_enc (
		.map (map_res),
		.res (enc_res)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s1) begin
			res_q <= enc_res;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.utf8_first  = res_q.first;
	assign out_ch.utf8_second = res_q.second;
	assign out_ch.utf8_third  = res_q.third;
	assign out_ch.byte_count  = res_q.count;
	assign out_ch.bad_input   = res_q.bad;

endmodule

// File: rtl/cc2u_checker.sv
// Port-level checks on the transcoder, bound to the top level.
`timescale 1ns / 1ps
`include "cyrillic_codepage_to_utf8_transcoder_defines.svh"

module cc2u_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] utf8_first,
	input logic [7:0] utf8_second,
	input logic [7:0] utf8_third,
	input logic [1:0] byte_count,
	input logic       bad_input
);

	// a stalled beat keeps its payload
	`CC2U_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable({utf8_first, utf8_second, utf8_third, byte_count, bad_input}), "stalled output beat changed")

	// with the result register empty the input side must be open
	`CC2U_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !out_valid, in_ready, "input stalled with empty output")

	// error flag and zero length go together, and an error carries no bytes
	`CC2U_ASSERT_NOW(a_bad_zero, clk, arst_n, out_valid, (bad_input == (byte_count == 2'd0)) && (!bad_input || (utf8_first == 8'd0 && utf8_second == 8'd0 && utf8_third == 8'd0)), "error beat malformed")

	// one-byte sequences are ASCII with unused bytes cleared
	`CC2U_ASSERT_NOW(a_one_byte, clk, arst_n, out_valid && byte_count == 2'd1, !utf8_first[7] && utf8_second == 8'd0 && utf8_third == 8'd0, "bad one-byte sequence")

	// multi-byte sequences have proper lead and continuation bytes
	`CC2U_ASSERT_NOW(a_multi_byte, clk, arst_n, out_valid && (byte_count == 2'd2 || byte_count == 2'd3), utf8_second[7:6] == 2'b10 && ((byte_count == 2'd2 && utf8_first[7:5] == 3'b110 && utf8_third == 8'd0) || (byte_count == 2'd3 && utf8_first[7:4] == 4'b1110 && utf8_third[7:6] == 2'b10)), "bad multi-byte sequence")

endmodule

bind cyrillic_codepage_to_utf8_transcoder cc2u_checker u_cc2u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.utf8_first  (out_ch.utf8_first),
	.utf8_second (out_ch.utf8_second),
	.utf8_third  (out_ch.utf8_third),
	.byte_count  (out_ch.byte_count),
	.bad_input   (out_ch.bad_input)
);
